/* rtl/sler_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sler_pkg
// Shared constants and controller/datapath interface types for the sprite
// line evaluate and render unit.
// ----------------------------------------------------------------------------
package sler_pkg;

    localparam int SPRITE_ENTRIES = 64;
    localparam int ATTR_BYTES     = SPRITE_ENTRIES * 4;
    localparam int SPR_IDX_W      = $clog2(SPRITE_ENTRIES);
    localparam int LINE_SLOTS     = 8;
    localparam int SLOT_W         = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int CNT_W          = $clog2(LINE_SLOTS + 1);
    localparam int PATTERN_BYTES  = 8192;
    localparam int PAT_AW         = $clog2(PATTERN_BYTES);
    localparam int NUM_W          = 6;

    localparam logic [1:0] OP_ATTR_WR = 2'd0;
    localparam logic [1:0] OP_PAT_WR  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic CFG_TALL  = 1'b0;
    localparam logic CFG_UPPER = 1'b1;

    localparam logic [7:0] HIDDEN_Y      = 8'd240;
    localparam logic [8:0] EVAL_DOT      = 9'd257;
    localparam logic [8:0] LAST_DRAW_DOT = 9'd256;
    localparam int         BIT_BEHIND    = 5;
    localparam int         BIT_HFLIP     = 6;
    localparam int         BIT_VFLIP     = 7;

    typedef struct packed {
        logic accept;
        logic clear_res;
        logic mem_write;
        logic eval_init;
        logic eval_read;
        logic eval_check;
        logic draw_init;
        logic draw_skip;
        logic draw_issue;
        logic draw_check;
        logic load_out;
    } sler_cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_eval;
        logic is_draw;
        logic eval_stop;
        logic idx_last;
        logic draw_done;
        logic in_range;
        logic ci_nonzero;
        logic out_free;
    } sler_status_t;

endpackage

/* rtl/sler_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sler_ctrl
// Sequencer: accepts one word at a time and steps the datapath through
// memory writes, the line scan and the per-dot slot search.
// ----------------------------------------------------------------------------
module sler_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sler_pkg::sler_status_t status,
    output sler_pkg::sler_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_DECODE     = 7'b0000010,
        ST_EVAL_RD    = 7'b0000100,
        ST_EVAL_CHK   = 7'b0001000,
        ST_DRAW_ISSUE = 7'b0010000,
        ST_DRAW_CHK   = 7'b0100000,
        ST_FINISH     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.clear_res = 1'b1;
                if (status.is_write)
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (status.is_eval)
                begin
                    cmd.eval_init = 1'b1;
                    state_next    = ST_EVAL_RD;
                end
                else if (status.is_draw)
                begin
                    cmd.draw_init = 1'b1;
                    state_next    = ST_DRAW_ISSUE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_EVAL_RD:
            begin
                cmd.eval_read = 1'b1;
                state_next    = ST_EVAL_CHK;
            end
            ST_EVAL_CHK:
            begin
                cmd.eval_check = 1'b1;
                if (status.eval_stop || status.idx_last)
                    state_next = ST_FINISH;
                else
                    state_next = ST_EVAL_RD;
            end
            ST_DRAW_ISSUE:
            begin
                if (status.draw_done)
                    state_next = ST_FINISH;
                else if (!status.in_range)
                    cmd.draw_skip = 1'b1;
                else
                begin
                    cmd.draw_issue = 1'b1;
                    state_next     = ST_DRAW_CHK;
                end
            end
            ST_DRAW_CHK:
            begin
                cmd.draw_check = 1'b1;
                if (status.ci_nonzero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DRAW_ISSUE;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/sler_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sler_datapath
// Attribute and pattern memories, line slot list, scan and draw arithmetic,
// result and output registers.
// ----------------------------------------------------------------------------
module sler_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic                                cfg_data,
    input  logic [1:0]                          op,
    input  logic [12:0]                         addr,
    input  logic [7:0]                          data,
    input  logic [8:0]                          scanline,
    input  logic [8:0]                          dot,
    input  logic                                pre_render,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                pixel_valid,
    output logic [2:0]                          palette_select,
    output logic [1:0]                          color_index,
    output logic                                behind_background,
    output logic [5:0]                          sprite_number,
    output logic                                overflow_set,
    input  sler_pkg::sler_cmd_t                 cmd,
    output sler_pkg::sler_status_t              status
);

    logic tall_reg;
    logic upper_reg;

    logic [1:0]  op_reg;
    logic [12:0] addr_reg;
    logic [7:0]  data_reg;
    logic [8:0]  line_reg;
    logic [8:0]  dot_reg;
    logic        pre_reg;

    logic [3:0][7:0] attr_mem [sler_pkg::SPRITE_ENTRIES];
    logic [7:0]      pat_mem  [sler_pkg::PATTERN_BYTES];
    logic [3:0][7:0] attr_rd_reg;
    logic [7:0]      pat_lo_reg;
    logic [7:0]      pat_hi_reg;

    logic [3:0][7:0]                 slot_reg [sler_pkg::LINE_SLOTS];
    logic [sler_pkg::NUM_W-1:0]      slot_num_reg [sler_pkg::LINE_SLOTS];
    logic [sler_pkg::CNT_W-1:0]      line_cnt_reg;
    logic [sler_pkg::SPR_IDX_W-1:0]  idx_reg;
    logic [sler_pkg::CNT_W-1:0]      draw_i_reg;

    logic       res_valid_reg;
    logic [2:0] res_pal_reg;
    logic [1:0] res_ci_reg;
    logic       res_behind_reg;
    logic [5:0] res_num_reg;
    logic       res_ovf_reg;

    logic       out_valid_reg;
    logic       out_pix_reg;
    logic [2:0] out_pal_reg;
    logic [1:0] out_ci_reg;
    logic       out_behind_reg;
    logic [5:0] out_num_reg;
    logic       out_ovf_reg;

    // scan compare
    logic [7:0] ey;
    logic [9:0] ediff;
    logic [4:0] height;
    logic       ematch;
    logic       slots_full;

    // draw arithmetic
    logic [3:0][7:0]           cur;
    logic [sler_pkg::SLOT_W-1:0] cur_i;
    logic [7:0]                xpos;
    logic [7:0]                cy;
    logic [7:0]                dx;
    logic [7:0]                row;
    logic [7:0]                tile;
    logic                      base_hi;
    logic [2:0]                bitsel;
    logic [1:0]                ci;

    assign ey     = attr_rd_reg[0];
    assign ediff  = {1'b0, line_reg} - {2'b0, ey};
    assign height = tall_reg ? 5'd16 : 5'd8;
    assign ematch = (ey < sler_pkg::HIDDEN_Y) && (line_reg >= {1'b0, ey})
                    && (ediff < {5'b0, height});
    assign slots_full = (line_cnt_reg == sler_pkg::CNT_W'(sler_pkg::LINE_SLOTS));

    assign cur_i = draw_i_reg[sler_pkg::SLOT_W-1:0];
    assign cur   = slot_reg[cur_i];
    assign xpos  = dot_reg[7:0] - 8'd1;
    assign cy    = line_reg[7:0] - 8'd1;
    assign dx    = xpos - cur[3];

    always_comb
    begin
        row     = cy - cur[0];
        tile    = cur[1];
        base_hi = 1'b0;
        if (!tall_reg)
        begin
            base_hi = upper_reg;
            if (cur[2][sler_pkg::BIT_VFLIP])
                row = 8'd7 - row;
        end
        else
        begin
            if (tile[0])
            begin
                base_hi = 1'b1;
                tile[0] = 1'b0;
            end
            if (cur[2][sler_pkg::BIT_VFLIP])
                row = 8'd15 - row;
            if (row >= 8'd8)
                tile = tile + 8'd1;
        end
    end

    assign bitsel = cur[2][sler_pkg::BIT_HFLIP] ? dx[2:0] : (3'd7 - dx[2:0]);
    assign ci     = {pat_hi_reg[bitsel], pat_lo_reg[bitsel]};

    always_comb
    begin
        status            = '0;
        status.is_write   = (op_reg == sler_pkg::OP_ATTR_WR) || (op_reg == sler_pkg::OP_PAT_WR);
        status.is_eval    = (op_reg == sler_pkg::OP_TICK) && !pre_reg
                            && (dot_reg == sler_pkg::EVAL_DOT);
        status.is_draw    = (op_reg == sler_pkg::OP_TICK) && !pre_reg && (line_reg != 9'd0)
                            && (dot_reg inside {[9'd1:sler_pkg::LAST_DRAW_DOT]});
        status.eval_stop  = ematch && slots_full;
        status.idx_last   = (idx_reg == sler_pkg::SPR_IDX_W'(sler_pkg::SPRITE_ENTRIES - 1));
        status.draw_done  = (draw_i_reg >= line_cnt_reg);
        status.in_range   = (xpos >= cur[3]) && (dx < 8'd8);
        status.ci_nonzero = (ci != 2'd0);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg  <= 1'b0;
            upper_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sler_pkg::CFG_TALL)
                tall_reg <= cfg_data;
            if (cfg_index == sler_pkg::CFG_UPPER)
                upper_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op;
            addr_reg <= addr;
            data_reg <= data;
            line_reg <= scanline;
            dot_reg  <= dot;
            pre_reg  <= pre_render;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && (op_reg == sler_pkg::OP_ATTR_WR)
            && (addr_reg < 13'(sler_pkg::ATTR_BYTES)))
            attr_mem[addr_reg[sler_pkg::SPR_IDX_W+1:2]][addr_reg[1:0]] <= data_reg;
        if (cmd.eval_read)
            attr_rd_reg <= attr_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && (op_reg == sler_pkg::OP_PAT_WR))
            pat_mem[addr_reg[sler_pkg::PAT_AW-1:0]] <= data_reg;
        if (cmd.draw_issue)
        begin
            pat_lo_reg <= pat_mem[{base_hi, tile, 1'b0, row[2:0]}];
            pat_hi_reg <= pat_mem[{base_hi, tile, 1'b1, row[2:0]}];
        end
    end

    // line slot list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_cnt_reg <= '0;
        else if (cmd.eval_init)
            line_cnt_reg <= '0;
        else if (cmd.eval_check && ematch && !slots_full)
            line_cnt_reg <= line_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_check && ematch && !slots_full)
        begin
            slot_reg[line_cnt_reg[sler_pkg::SLOT_W-1:0]]     <= attr_rd_reg;
            slot_num_reg[line_cnt_reg[sler_pkg::SLOT_W-1:0]] <= sler_pkg::NUM_W'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            draw_i_reg <= '0;
        end
        else
        begin
            if (cmd.eval_init)
                idx_reg <= '0;
            else if (cmd.eval_check)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.draw_init)
                draw_i_reg <= '0;
            else if (cmd.draw_skip || (cmd.draw_check && (ci == 2'd0)))
                draw_i_reg <= draw_i_reg + 1'b1;
        end
    end

    // result
    always_ff @(posedge clk)
    begin
        if (cmd.clear_res)
        begin
            res_valid_reg  <= 1'b0;
            res_pal_reg    <= '0;
            res_ci_reg     <= '0;
            res_behind_reg <= 1'b0;
            res_num_reg    <= '0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.eval_check && ematch && slots_full)
                res_ovf_reg <= 1'b1;
            if (cmd.draw_check && (ci != 2'd0))
            begin
                res_valid_reg  <= 1'b1;
                res_pal_reg    <= {1'b1, cur[2][1:0]};
                res_ci_reg     <= ci;
                res_behind_reg <= cur[2][sler_pkg::BIT_BEHIND];
                res_num_reg    <= slot_num_reg[cur_i];
            end
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pix_reg    <= res_valid_reg;
            out_pal_reg    <= res_pal_reg;
            out_ci_reg     <= res_ci_reg;
            out_behind_reg <= res_behind_reg;
            out_num_reg    <= res_num_reg;
            out_ovf_reg    <= res_ovf_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pixel_valid       = out_pix_reg;
    assign palette_select    = out_pal_reg;
    assign color_index       = out_ci_reg;
    assign behind_background = out_behind_reg;
    assign sprite_number     = out_num_reg;
    assign overflow_set      = out_ovf_reg;

endmodule

/* rtl/sprite_line_evaluate_render_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_line_evaluate_render_unit
// Sprite evaluation and pixel selection for a tile-based video processor.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one word: an attribute byte
// write, a pattern byte write or a dot tick. Every accepted word produces
// exactly one output word (out_valid/out_stall).
// One word is in flight at a time; in_stall is high while it is worked on,
// and the next word can be taken in the same cycle that out_valid rises.
// Steps from accept to out_valid:
//   writes and idle ticks: decode, then finish
//   dot 257 scan: a read and a check per attribute entry through the single
//     attribute read port, until the last entry or until overflow stops the scan
//   drawing dots: a skip for each kept sprite out of x range; a pattern memory
//     read and a check for each in-range sprite, until a pixel is found or all
//     kept sprites are tried
// A finished word sits in the output register; the next input word is taken
// while it waits. If out_stall is held, the following result waits in the
// finish step and the input stalls.
// Configuration writes (cfg_we) take effect at once; the user must make them only
// while idle, as the block does not enforce it. Reset clears the controls, the kept
// sprite count and the configuration; the attribute and pattern memories are not cleared.
// ----------------------------------------------------------------------------
module sprite_line_evaluate_render_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [12:0] addr,
    input  logic [7:0]  data,
    input  logic [8:0]  scanline,
    input  logic [8:0]  dot,
    input  logic        pre_render,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pixel_valid,
    output logic [2:0]  palette_select,
    output logic [1:0]  color_index,
    output logic        behind_background,
    output logic [5:0]  sprite_number,
    output logic        overflow_set
);

    sler_pkg::sler_cmd_t    cmd;
    sler_pkg::sler_status_t status;

    sler_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sler_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .op                (op),
        .addr              (addr),
        .data              (data),
        .scanline          (scanline),
        .dot               (dot),
        .pre_render        (pre_render),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .pixel_valid       (pixel_valid),
        .palette_select    (palette_select),
        .color_index       (color_index),
        .behind_background (behind_background),
        .sprite_number     (sprite_number),
        .overflow_set      (overflow_set),
        .cmd               (cmd),
        .status            (status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a word is in flight");

    a_pixel_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_valid) |-> ((color_index != 2'd0) && palette_select[2]))
        else $error("reported sprite pixel is transparent or has bad palette");

    a_ovf_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow_set && pixel_valid))
        else $error("overflow and pixel in one word");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_valid) |-> ((color_index == 2'd0) && (sprite_number == 6'd0)))
        else $error("fields set without a pixel");

endmodule

/* tb/sv/sprite_line_evaluate_render_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_line_evaluate_render_unit_test
// Loads the attribute memory and the pattern tiles in use, then runs directed
// and random words (sprite setups, line scans at dot 257, drawing dots,
// noise) under several sprite size and table settings with random idling on
// both sides. A scoreboard predicts one result word per input word and
// checks each field of every result.
// ----------------------------------------------------------------------------
module sprite_line_evaluate_render_unit_test;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         RANDOM_WORDS = 800;
    localparam int         TILE_COUNT   = 4;

    typedef struct packed {
        logic       pixel_valid;
        logic [2:0] palette_select;
        logic [1:0] color_index;
        logic       behind_background;
        logic [5:0] sprite_number;
        logic       overflow_set;
    } pixel_word_t;

    class sprite_scoreboard;
        logic [7:0]  oam [sler_pkg::ATTR_BYTES];
        logic [7:0]  chr [sler_pkg::PATTERN_BYTES];
        logic [7:0]  slot_y [sler_pkg::LINE_SLOTS];
        logic [7:0]  slot_tile [sler_pkg::LINE_SLOTS];
        logic [7:0]  slot_attr [sler_pkg::LINE_SLOTS];
        logic [7:0]  slot_x [sler_pkg::LINE_SLOTS];
        logic [5:0]  slot_num [sler_pkg::LINE_SLOTS];
        int          kept;
        logic        tall;
        logic        upper;
        pixel_word_t pending [$];
        int          errors;

        function new();
            kept = 0;
            tall = 0;
            upper = 0;
            errors = 0;
        endfunction

        function logic scan_line(logic [8:0] line);
            int h;
            h = tall ? 16 : 8;
            kept = 0;
            for (int i = 0; i < sler_pkg::SPRITE_ENTRIES; i++)
            begin
                if (oam[i*4] >= sler_pkg::HIDDEN_Y)
                    continue;
                if (line >= oam[i*4] && line - oam[i*4] < h)
                begin
                    if (kept >= sler_pkg::LINE_SLOTS)
                        return 1'b1;
                    slot_y[kept]    = oam[i*4];
                    slot_tile[kept] = oam[i*4+1];
                    slot_attr[kept] = oam[i*4+2];
                    slot_x[kept]    = oam[i*4+3];
                    slot_num[kept]  = i[5:0];
                    kept++;
                end
            end
            return 1'b0;
        endfunction

        function void draw(logic [8:0] line, logic [8:0] dot, inout pixel_word_t r);
            logic [7:0]  px, cy, row, tile, lo, hi;
            logic [12:0] base, a;
            int          dx, sh;
            logic [1:0]  ci;
            px = 8'(dot - 9'd1);
            cy = 8'(line - 9'd1);
            for (int i = 0; i < kept; i++)
            begin
                if (px < slot_x[i] || px - slot_x[i] >= 8)
                    continue;
                dx = px - slot_x[i];
                row = cy - slot_y[i];
                tile = slot_tile[i];
                base = '0;
                if (!tall)
                begin
                    if (upper)
                        base = 13'h1000;
                    if (slot_attr[i][sler_pkg::BIT_VFLIP])
                        row = 8'd7 - row;
                end
                else
                begin
                    if (tile[0])
                    begin
                        base = 13'h1000;
                        tile[0] = 1'b0;
                    end
                    if (slot_attr[i][sler_pkg::BIT_VFLIP])
                        row = 8'd15 - row;
                    if (row >= 8)
                        tile = tile + 8'd1;
                end
                a = base + {tile, 4'd0} + row[2:0];
                lo = chr[a];
                hi = chr[13'(a + 13'd8)];
                sh = slot_attr[i][sler_pkg::BIT_HFLIP] ? dx : 7 - dx;
                ci = {hi[sh], lo[sh]};
                if (ci == 2'd0)
                    continue;
                r.pixel_valid = 1'b1;
                r.palette_select = 3'd4 + slot_attr[i][1:0];
                r.color_index = ci;
                r.behind_background = slot_attr[i][sler_pkg::BIT_BEHIND];
                r.sprite_number = slot_num[i];
                return;
            end
        endfunction

        function void note_word(logic [1:0] o, logic [12:0] a, logic [7:0] d,
                                logic [8:0] line, logic [8:0] dt, logic pre);
            pixel_word_t r;
            r = '0;
            if (o == sler_pkg::OP_ATTR_WR)
            begin
                if (a < sler_pkg::ATTR_BYTES)
                    oam[a] = d;
            end
            else if (o == sler_pkg::OP_PAT_WR)
                chr[a] = d;
            else if (o == sler_pkg::OP_TICK && !pre)
            begin
                if (dt == sler_pkg::EVAL_DOT)
                    r.overflow_set = scan_line(line);
                if (dt >= 1 && dt <= sler_pkg::LAST_DRAW_DOT && line != 0)
                    draw(line, dt, r);
            end
            pending.push_back(r);
        endfunction

        function void check_word(pixel_word_t act);
            pixel_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, act);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (act.pixel_valid !== exp_w.pixel_valid)
                $display("%0t: pixel_valid exp %h got %h", $time,
                         exp_w.pixel_valid, act.pixel_valid);
            if (act.palette_select !== exp_w.palette_select)
                $display("%0t: palette_select exp %h got %h", $time,
                         exp_w.palette_select, act.palette_select);
            if (act.color_index !== exp_w.color_index)
                $display("%0t: color_index exp %h got %h", $time,
                         exp_w.color_index, act.color_index);
            if (act.behind_background !== exp_w.behind_background)
                $display("%0t: behind_background exp %h got %h", $time,
                         exp_w.behind_background, act.behind_background);
            if (act.sprite_number !== exp_w.sprite_number)
                $display("%0t: sprite_number exp %h got %h", $time,
                         exp_w.sprite_number, act.sprite_number);
            if (act.overflow_set !== exp_w.overflow_set)
                $display("%0t: overflow_set exp %h got %h", $time,
                         exp_w.overflow_set, act.overflow_set);
            if (act !== exp_w)
                errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic [8:0]  dot;
    logic        pre_render;
    logic        out_valid;
    logic        out_stall;
    logic        pixel_valid;
    logic [2:0]  palette_select;
    logic [1:0]  color_index;
    logic        behind_background;
    logic [5:0]  sprite_number;
    logic        overflow_set;

    sprite_scoreboard sb = new();
    int  words_sent = 0;
    int  calm_from  = 0;
    logic calm;

    assign calm = words_sent >= calm_from && words_sent < calm_from + 300;

    sprite_line_evaluate_render_unit i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .addr(addr),
        .data(data),
        .scanline(scanline),
        .dot(dot),
        .pre_render(pre_render),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_valid(pixel_valid),
        .palette_select(palette_select),
        .color_index(color_index),
        .behind_background(behind_background),
        .sprite_number(sprite_number),
        .overflow_set(overflow_set)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 15);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_word({pixel_valid, palette_select, color_index,
                           behind_background, sprite_number, overflow_set});

    task automatic send(input logic [1:0] o, input logic [12:0] a, input logic [7:0] d,
                        input logic [8:0] line, input logic [8:0] dt, input logic pre);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        addr       <= a;
        data       <= d;
        scanline   <= line;
        dot        <= dt;
        pre_render <= pre;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(o, a, d, line, dt, pre);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic t, input logic u);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sler_pkg::CFG_TALL;
        cfg_data <= t;
        @(negedge clk);
        cfg_index <= sler_pkg::CFG_UPPER;
        cfg_data <= u;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.tall = t;
        sb.upper = u;
    endtask

    task automatic sprite_line();
        int          n;
        int          idx;
        logic [8:0]  line;
        logic [7:0]  sx [12];
        logic [7:0]  y;
        line = 9'($urandom_range(0, 239));
        n = $urandom_range(0, 12);
        for (int k = 0; k < n; k++)
        begin
            idx = $urandom_range(0, sler_pkg::SPRITE_ENTRIES - 1);
            y = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(240, 255))
                                             : 8'(line - $urandom_range(0, 17));
            sx[k] = 8'($urandom);
            send(sler_pkg::OP_ATTR_WR, 13'(idx*4), y, '0, '0, 1'b0);
            send(sler_pkg::OP_ATTR_WR, 13'(idx*4+1), 8'($urandom_range(0, TILE_COUNT - 1)),
                 '0, '0, 1'b0);
            send(sler_pkg::OP_ATTR_WR, 13'(idx*4+2), 8'($urandom), '0, '0, 1'b0);
            send(sler_pkg::OP_ATTR_WR, 13'(idx*4+3), sx[k], '0, '0, 1'b0);
        end
        if ($urandom_range(0, 2) == 0)
            send(sler_pkg::OP_PAT_WR, 13'($urandom), 8'($urandom), '0, '0, 1'b0);
        send(sler_pkg::OP_TICK, 13'($urandom), 8'($urandom), line, sler_pkg::EVAL_DOT,
             $urandom_range(0, 9) == 0);
        repeat ($urandom_range(5, 25))
        begin
            if (n > 0 && $urandom_range(0, 3) != 0)
                send(sler_pkg::OP_TICK, 13'($urandom), 8'($urandom), line + 9'd1,
                     9'(sx[$urandom_range(0, n - 1)] + $urandom_range(0, 9)),
                     $urandom_range(0, 19) == 0);
            else
                send(sler_pkg::OP_TICK, 13'($urandom), 8'($urandom), line + 9'd1,
                     9'($urandom_range(0, 340)), 1'b0);
        end
    endtask

    initial
    begin
        logic [1:0]  rnd_op;
        logic [12:0] rnd_addr;
        logic [7:0]  rnd_data;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        op = sler_pkg::OP_TICK;
        addr = '0;
        data = '0;
        scanline = '0;
        dot = '0;
        pre_render = 1'b0;
        calm_from = 1000000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_mode(1'b0, 1'b0);
        // tile bytes stay below TILE_COUNT, so only these patterns are read
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < TILE_COUNT * 16; i++)
                send(sler_pkg::OP_PAT_WR, 13'(t * 4096 + i), 8'($urandom), 9'($urandom),
                     9'($urandom), 1'($urandom));
        for (int i = 0; i < sler_pkg::ATTR_BYTES; i++)
            send(sler_pkg::OP_ATTR_WR, 13'(i),
                 (i % 4 == 1) ? 8'($urandom_range(0, TILE_COUNT - 1)) : 8'($urandom),
                 '0, '0, 1'b0);

        // directed corners
        send(sler_pkg::OP_ATTR_WR, 13'd256, 8'hff, '0, '0, 1'b0);
        send(sler_pkg::OP_ATTR_WR, 13'h1fff, 8'h00, 9'h1ff, 9'h1ff, 1'b1);
        send(sler_pkg::OP_PAT_WR, 13'h1fff, 8'hff, '0, '0, 1'b0);
        send(OP_NONE, 13'h1fff, 8'hff, 9'h1ff, 9'h1ff, 1'b1);
        for (int i = 0; i < 10; i++)
        begin
            send(sler_pkg::OP_ATTR_WR, 13'(i*4), 8'd40, '0, '0, 1'b0);
            send(sler_pkg::OP_ATTR_WR, 13'(i*4+3), 8'(i*3), '0, '0, 1'b0);
        end
        send(sler_pkg::OP_ATTR_WR, 13'd40, 8'd240, '0, '0, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd44, sler_pkg::EVAL_DOT, 1'b1);
        send(sler_pkg::OP_TICK, '0, '0, 9'd44, sler_pkg::EVAL_DOT, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd45, 9'd1, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd45, 9'd12, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd45, sler_pkg::LAST_DRAW_DOT, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd0, 9'd5, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd45, 9'd0, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd300, sler_pkg::EVAL_DOT, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'h1ff, 9'd340, 1'b0);
        send(sler_pkg::OP_TICK, '0, '0, 9'd261, 9'h1ff, 1'b0);

        calm_from = words_sent + 500;
        for (int p = 0; p < 8; p++)
        begin
            set_mode(p[0], p[1] ^ p[2]);
            while (words_sent < calm_from - 500 + (p + 1) * RANDOM_WORDS / 8)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    rnd_op   = 2'($urandom);
                    rnd_addr = 13'($urandom);
                    rnd_data = 8'($urandom);
                    if (rnd_op == sler_pkg::OP_ATTR_WR && rnd_addr[1:0] == 2'd1)
                        rnd_data = 8'(rnd_data % TILE_COUNT);
                    send(rnd_op, rnd_addr, rnd_data, 9'($urandom), 9'($urandom),
                         1'($urandom));
                end
                else
                    sprite_line();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
